### hw/rtl/pblru_pkg.sv
// ----------------------------------------------------------------------------
// pblru_pkg
// Shared types, constants and helpers of the LRU page buffer pool.
// ----------------------------------------------------------------------------
package pblru_pkg;

    localparam int BUFFER_SLOTS = 16;
    localparam int SLOT_W       = $clog2(BUFFER_SLOTS);
    localparam int SLOT_FIELD_W = 4;
    localparam int PAGE_W       = 16;
    localparam int STAMP_W      = 32;
    localparam int CMD_W        = 2;
    localparam int CFG_W        = 5;
    localparam int GROUP_SIZE   = 4;
    localparam int GROUPS       = (BUFFER_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_SLOTS_IN_USE = 3'd0;
    localparam logic [CFG_W-1:0]      SLOTS_IN_USE_RST  = 5'd16;

    localparam logic [CMD_W-1:0] OP_ACCESS = 2'd0;
    localparam logic [CMD_W-1:0] OP_CREATE = 2'd1;
    localparam logic [CMD_W-1:0] OP_DROP   = 2'd2;
    localparam logic [CMD_W-1:0] OP_FLUSH  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RESOLVE,
        ST_FLUSH
    } pblru_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
        logic flush_step;
    } pblru_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic is_flush;
        logic flush_more;
    } pblru_sts_t;

    // eviction candidate
    typedef struct packed {
        logic               v;
        logic [STAMP_W-1:0] stamp;
        logic [PAGE_W-1:0]  page;
        logic [SLOT_W-1:0]  idx;
    } pblru_cand_t;

    function automatic logic [SLOT_W-1:0] lowest_set(input logic [BUFFER_SLOTS-1:0] m);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    // a is the lower slot, so it wins ties
    function automatic pblru_cand_t cand_min(input pblru_cand_t a, input pblru_cand_t b);
        if (a.v && (!b.v || a.stamp <= b.stamp)) begin
            return a;
        end
        return b;
    endfunction

endpackage

### hw/rtl/pblru_in_if.sv
// ----------------------------------------------------------------------------
// pblru_in_if
// Command channel of the page buffer pool.
// ----------------------------------------------------------------------------
interface pblru_in_if
    import pblru_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_id;

    modport source (output valid, output cmd, output page_id, input ready);
    modport sink   (input valid, input cmd, input page_id, output ready);
endinterface

### hw/rtl/pblru_out_if.sv
// ----------------------------------------------------------------------------
// pblru_out_if
// Result channel of the page buffer pool.
// ----------------------------------------------------------------------------
interface pblru_out_if
    import pblru_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PAGE_W-1:0]       page_number;
    logic                    writeback_valid;
    logic [PAGE_W-1:0]       writeback_page;
    logic                    last;

    modport source (output valid, output hit, output slot, output page_number,
                    output writeback_valid, output writeback_page, output last,
                    input ready);
    modport sink   (input valid, input hit, input slot, input page_number,
                    input writeback_valid, input writeback_page, input last,
                    output ready);
endinterface

### hw/rtl/pblru_ctrl.sv
// ----------------------------------------------------------------------------
// pblru_ctrl
// Sequencer: accept, evaluate, resolve or step through a flush.
// ----------------------------------------------------------------------------
module pblru_ctrl
    import pblru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pblru_sts_t sts,
    output pblru_ctl_t ctl
);

    pblru_state_t state_reg;
    pblru_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                ctl.eval   = 1'b1;
                state_next = sts.is_flush ? ST_FLUSH : ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    ctl.flush_step = 1'b1;
                    if (!sts.flush_more) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/pblru_dp.sv
// ----------------------------------------------------------------------------
// pblru_dp
// Slot tables, tag compare, two-stage LRU search and result register.
// ----------------------------------------------------------------------------
module pblru_dp
    import pblru_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pblru_ctl_t              ctl,
    output pblru_sts_t              sts,
    input  logic [BUFFER_SLOTS-1:0] active_mask,
    input  logic [CMD_W-1:0]        in_cmd,
    input  logic [PAGE_W-1:0]       in_page_id,
    pblru_out_if.source             out_ch
);

    // slot tables
    logic [BUFFER_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [PAGE_W-1:0]       slot_page_reg  [BUFFER_SLOTS];
    logic [PAGE_W-1:0]       slot_page_next [BUFFER_SLOTS];
    logic [STAMP_W-1:0]      slot_stamp_reg [BUFFER_SLOTS];
    logic [STAMP_W-1:0]      slot_stamp_next[BUFFER_SLOTS];
    logic [STAMP_W-1:0]      use_clock_reg, use_clock_next;
    logic [PAGE_W-1:0]       next_new_page_reg, next_new_page_next;

    // captured transaction
    logic [CMD_W-1:0]        item_cmd_reg, item_cmd_next;
    logic [PAGE_W-1:0]       item_page_reg, item_page_next;

    // evaluation results
    logic [BUFFER_SLOTS-1:0] match_mask_reg, match_mask_next;
    logic [BUFFER_SLOTS-1:0] empty_mask_reg, empty_mask_next;
    pblru_cand_t             grp_reg [GROUPS];
    pblru_cand_t             grp_next[GROUPS];
    logic [BUFFER_SLOTS-1:0] flush_mask_reg, flush_mask_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic [PAGE_W-1:0]       out_page_reg, out_page_next;
    logic                    out_wbv_reg, out_wbv_next;
    logic [PAGE_W-1:0]       out_wbp_reg, out_wbp_next;
    logic                    out_last_reg, out_last_next;

    logic [BUFFER_SLOTS-1:0] match_comb;
    logic [BUFFER_SLOTS-1:0] flush_rest;
    logic [SLOT_W-1:0]       flush_idx;
    logic [SLOT_W-1:0]       hit_slot;
    logic [SLOT_W-1:0]       victim;
    logic [PAGE_W-1:0]       new_page;
    logic                    out_free;
    pblru_cand_t             lru;

    assign out_free = !out_valid_reg || out_ch.ready;

    assign flush_idx  = lowest_set(flush_mask_reg);
    assign flush_rest = flush_mask_reg & ~(BUFFER_SLOTS'(1) << flush_idx);
    assign hit_slot   = lowest_set(match_mask_reg);

    assign sts.out_free   = out_free;
    assign sts.is_flush   = (item_cmd_reg == OP_FLUSH);
    assign sts.flush_more = |flush_rest;

    // stage 1: tag compare and per-group minimum
    always_comb begin
        pblru_cand_t c;
        int          idx;
        for (int i = 0; i < BUFFER_SLOTS; i++) begin
            match_comb[i] = slot_valid_reg[i] && active_mask[i]
                            && (slot_page_reg[i] == item_page_reg);
        end
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                idx = g * GROUP_SIZE + k;
                if (idx < BUFFER_SLOTS) begin
                    c.v         = slot_valid_reg[idx] && active_mask[idx];
                    c.stamp     = slot_stamp_reg[idx];
                    c.page      = slot_page_reg[idx];
                    c.idx       = SLOT_W'(idx);
                    grp_next[g] = cand_min(grp_next[g], c);
                end
            end
            if (!ctl.eval) begin
                grp_next[g] = grp_reg[g];
            end
        end
    end

    // stage 2: final minimum over the groups
    always_comb begin
        lru = '0;
        for (int g = 0; g < GROUPS; g++) begin
            lru = cand_min(lru, grp_reg[g]);
        end
    end

    assign victim   = (|empty_mask_reg) ? lowest_set(empty_mask_reg) : lru.idx;
    assign new_page = (item_cmd_reg == OP_CREATE) ? next_new_page_reg : item_page_reg;

    always_comb begin
        slot_valid_next    = slot_valid_reg;
        slot_page_next     = slot_page_reg;
        slot_stamp_next    = slot_stamp_reg;
        use_clock_next     = use_clock_reg;
        next_new_page_next = next_new_page_reg;
        item_cmd_next      = ctl.load ? in_cmd : item_cmd_reg;
        item_page_next     = ctl.load ? in_page_id : item_page_reg;
        match_mask_next    = ctl.eval ? match_comb : match_mask_reg;
        empty_mask_next    = ctl.eval ? (~slot_valid_reg & active_mask) : empty_mask_reg;
        flush_mask_next    = flush_mask_reg;
        out_valid_next     = out_valid_reg && !out_ch.ready;
        out_hit_next       = out_hit_reg;
        out_slot_next      = out_slot_reg;
        out_page_next      = out_page_reg;
        out_wbv_next       = out_wbv_reg;
        out_wbp_next       = out_wbp_reg;
        out_last_next      = out_last_reg;

        if (ctl.eval && (item_cmd_reg == OP_FLUSH)) begin
            flush_mask_next = slot_valid_reg & active_mask;
        end

        if (ctl.commit) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            case (item_cmd_reg)
                OP_DROP: begin
                    // every matching slot goes, the lowest is reported
                    slot_valid_next = slot_valid_reg & ~match_mask_reg;
                    out_hit_next    = |match_mask_reg;
                    out_slot_next   = (|match_mask_reg) ? SLOT_FIELD_W'(hit_slot) : '0;
                    out_page_next   = item_page_reg;
                    out_wbv_next    = 1'b0;
                    out_wbp_next    = '0;
                end
                default: begin
                    if (use_clock_reg != '1) begin
                        use_clock_next = use_clock_reg + STAMP_W'(1);
                    end
                    if ((item_cmd_reg == OP_ACCESS) && (|match_mask_reg)) begin
                        slot_stamp_next[hit_slot] = use_clock_reg;
                        out_hit_next  = 1'b1;
                        out_slot_next = SLOT_FIELD_W'(hit_slot);
                        out_page_next = item_page_reg;
                        out_wbv_next  = 1'b0;
                        out_wbp_next  = '0;
                    end
                    else begin
                        if (item_cmd_reg == OP_CREATE) begin
                            next_new_page_next = next_new_page_reg + PAGE_W'(1);
                        end
                        slot_valid_next[victim] = 1'b1;
                        slot_page_next[victim]  = new_page;
                        slot_stamp_next[victim] = use_clock_reg;
                        out_hit_next  = 1'b0;
                        out_slot_next = SLOT_FIELD_W'(victim);
                        out_page_next = new_page;
                        out_wbv_next  = ~(|empty_mask_reg);
                        out_wbp_next  = (|empty_mask_reg) ? '0 : lru.page;
                    end
                end
            endcase
        end

        if (ctl.flush_step) begin
            out_valid_next = 1'b1;
            out_hit_next   = 1'b0;
            if (|flush_mask_reg) begin
                slot_valid_next[flush_idx] = 1'b0;
                flush_mask_next            = flush_rest;
                out_slot_next              = SLOT_FIELD_W'(flush_idx);
                out_page_next              = slot_page_reg[flush_idx];
                out_wbv_next               = 1'b1;
                out_wbp_next               = slot_page_reg[flush_idx];
                out_last_next              = ~(|flush_rest);
            end
            else begin
                // nothing resident: single result with only last set
                out_slot_next = '0;
                out_page_next = '0;
                out_wbv_next  = 1'b0;
                out_wbp_next  = '0;
                out_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slot_valid_reg    <= '0;
            use_clock_reg     <= '0;
            next_new_page_reg <= '0;
            flush_mask_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else begin
            slot_valid_reg    <= slot_valid_next;
            use_clock_reg     <= use_clock_next;
            next_new_page_reg <= next_new_page_next;
            flush_mask_reg    <= flush_mask_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        slot_page_reg  <= slot_page_next;
        slot_stamp_reg <= slot_stamp_next;
        item_cmd_reg   <= item_cmd_next;
        item_page_reg  <= item_page_next;
        match_mask_reg <= match_mask_next;
        empty_mask_reg <= empty_mask_next;
        grp_reg        <= grp_next;
        out_hit_reg    <= out_hit_next;
        out_slot_reg   <= out_slot_next;
        out_page_reg   <= out_page_next;
        out_wbv_reg    <= out_wbv_next;
        out_wbp_reg    <= out_wbp_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.hit             = out_hit_reg;
    assign out_ch.slot            = out_slot_reg;
    assign out_ch.page_number     = out_page_reg;
    assign out_ch.writeback_valid = out_wbv_reg;
    assign out_ch.writeback_page  = out_wbp_reg;
    assign out_ch.last            = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit || ctl.flush_step) |-> (!out_valid_reg || out_ch.ready))
        else $error("result register loaded while a result is pending");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit || ctl.flush_step) |=> out_valid_reg)
        else $error("produced result not presented");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        use_clock_reg >= $past(use_clock_reg))
        else $error("use clock went backwards");

    a_flush_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (flush_mask_reg & ~slot_valid_reg) == '0)
        else $error("flush pending on an empty slot");

endmodule

### hw/rtl/page_buffer_lru_replacement.sv
// ----------------------------------------------------------------------------
// page_buffer_lru_replacement
// LRU buffer pool of page slots with APB slot-count register.
// ----------------------------------------------------------------------------
// Access, create and drop step the sequencer through its idle, evaluate and
// resolve states. The idle step captures the command. The evaluate step runs
// the tag compare and the per-group LRU minimum. The resolve step makes the
// final pick, updates the tables and loads the output register. The next
// command is accepted in the cycle after the result is loaded, so a new
// command is not taken before the last one's result is loaded. A flush steps
// through the resident slots (a single result when none is resident), one
// writeback transaction per cycle while the result side keeps up. While a
// result waits, the command side still takes one more command. A stalled
// result side holds the sequencer at its result step. Register slots_in_use
// sits at byte address 0 and resets to 16.
// ----------------------------------------------------------------------------
module page_buffer_lru_replacement
    import pblru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    pblru_in_if.sink              in_ch,
    pblru_out_if.source           out_ch
);

    logic [CFG_W-1:0]        slots_in_use_reg, slots_in_use_next;
    logic [BUFFER_SLOTS-1:0] active_mask;
    logic                    cfg_write;
    pblru_ctl_t              ctl;
    pblru_sts_t              sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_SLOTS_IN_USE);
    assign prdata    = (paddr == ADDR_SLOTS_IN_USE) ? APB_DATA_W'(slots_in_use_reg) : '0;

    assign slots_in_use_next = cfg_write ? pwdata[CFG_W-1:0] : slots_in_use_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slots_in_use_reg <= SLOTS_IN_USE_RST;
        end
        else begin
            slots_in_use_reg <= slots_in_use_next;
        end
    end

    // zero acts as one slot, oversized counts as all slots
    always_comb begin
        for (int i = 0; i < BUFFER_SLOTS; i++) begin
            active_mask[i] = (i == 0) || (i < int'(slots_in_use_reg));
        end
    end

    pblru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    pblru_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .active_mask (active_mask),
        .in_cmd      (in_ch.cmd),
        .in_page_id  (in_ch.page_id),
        .out_ch      (out_ch)
    );

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU page buffer pool. A queue-fed driver offers
// access, create, drop and flush commands. A shadow pool model predicts every
// result transaction, and a monitor compares each transaction field by field.
// The slot count is changed over APB between traffic phases.
// ----------------------------------------------------------------------------
module tb_top
    import pblru_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [PAGE_W-1:0] page;
    } pool_cmd_t;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [PAGE_W-1:0]       page_number;
        logic                    wb_valid;
        logic [PAGE_W-1:0]       wb_page;
        logic                    last;
    } pool_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic              cmd_valid = 1'b0;
    logic [CMD_W-1:0]  cmd_op    = '0;
    logic [PAGE_W-1:0] cmd_page  = '0;
    logic              res_ready = 1'b0;

    pblru_in_if  cmd_if ();
    pblru_out_if res_if ();

    assign cmd_if.valid   = cmd_valid;
    assign cmd_if.cmd     = cmd_op;
    assign cmd_if.page_id = cmd_page;
    assign res_if.ready   = res_ready;

    page_buffer_lru_replacement dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (cmd_if),
        .out_ch  (res_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the pool
    bit                 resident      [BUFFER_SLOTS];
    logic [PAGE_W-1:0]  resident_page [BUFFER_SLOTS];
    logic [STAMP_W-1:0] use_stamp     [BUFFER_SLOTS];
    logic [STAMP_W-1:0] stamp_clock   = '0;
    logic [PAGE_W-1:0]  new_page_ctr  = '0;
    logic [CFG_W-1:0]   pool_size_reg = SLOTS_IN_USE_RST;

    pool_cmd_t    cmd_backlog[$];
    pool_result_t pending_results[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int stall_seen     = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int regread_errors = 0;

    function automatic int unsigned active_depth();
        if (pool_size_reg == 0)
        begin
            return 1;
        end
        if (pool_size_reg > BUFFER_SLOTS)
        begin
            return BUFFER_SLOTS;
        end
        return 32'(pool_size_reg);
    endfunction

    function automatic void stamp_slot(int unsigned s);
        use_stamp[s] = stamp_clock;
        if (stamp_clock != '1)
        begin
            stamp_clock = stamp_clock + STAMP_W'(1);
        end
    endfunction

    // lowest empty slot, else the oldest stamp (lowest slot on ties)
    function automatic void place_page(logic [PAGE_W-1:0] pg);
        int unsigned  n;
        int unsigned  victim;
        bit           found_empty;
        logic [STAMP_W-1:0] oldest;
        pool_result_t r;
        n           = active_depth();
        victim      = 0;
        found_empty = 1'b0;
        r           = '0;
        for (int unsigned s = 0; s < n; s++)
        begin
            if (!found_empty && !resident[s])
            begin
                victim      = s;
                found_empty = 1'b1;
            end
        end
        if (!found_empty)
        begin
            oldest = use_stamp[0];
            for (int unsigned s = 1; s < n; s++)
            begin
                if (use_stamp[s] < oldest)
                begin
                    oldest = use_stamp[s];
                    victim = s;
                end
            end
            r.wb_valid = 1'b1;
            r.wb_page  = resident_page[victim];
        end
        resident[victim]      = 1'b1;
        resident_page[victim] = pg;
        stamp_slot(victim);
        r.slot        = SLOT_FIELD_W'(victim);
        r.page_number = pg;
        r.last        = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_pool_command(pool_cmd_t c);
        int unsigned  n;
        int           first;
        int           last_idx;
        pool_result_t r;
        n        = active_depth();
        first    = -1;
        last_idx = -1;
        r        = '0;
        case (c.op)
            OP_ACCESS:
            begin
                for (int unsigned s = 0; s < n; s++)
                begin
                    if (first < 0 && resident[s] && resident_page[s] == c.page)
                    begin
                        first = s;
                    end
                end
                if (first >= 0)
                begin
                    stamp_slot(first);
                    r.hit         = 1'b1;
                    r.slot        = SLOT_FIELD_W'(first);
                    r.page_number = c.page;
                    r.last        = 1'b1;
                    pending_results.push_back(r);
                end
                else
                begin
                    place_page(c.page);
                end
            end
            OP_CREATE:
            begin
                place_page(new_page_ctr);
                new_page_ctr = new_page_ctr + PAGE_W'(1);
            end
            OP_DROP:
            begin
                // every copy goes, the lowest one is reported
                for (int unsigned s = 0; s < n; s++)
                begin
                    if (resident[s] && resident_page[s] == c.page)
                    begin
                        if (first < 0)
                        begin
                            first = s;
                        end
                        resident[s] = 1'b0;
                    end
                end
                r.hit         = (first >= 0);
                r.slot        = (first >= 0) ? SLOT_FIELD_W'(first) : '0;
                r.page_number = c.page;
                r.last        = 1'b1;
                pending_results.push_back(r);
            end
            default:
            begin
                // flush
                for (int unsigned s = 0; s < n; s++)
                begin
                    if (resident[s])
                    begin
                        last_idx = s;
                    end
                end
                if (last_idx < 0)
                begin
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                for (int unsigned s = 0; s < n; s++)
                begin
                    if (resident[s])
                    begin
                        r             = '0;
                        r.slot        = SLOT_FIELD_W'(s);
                        r.page_number = resident_page[s];
                        r.wb_valid    = 1'b1;
                        r.wb_page     = resident_page[s];
                        r.last        = (s == last_idx);
                        pending_results.push_back(r);
                        resident[s] = 1'b0;
                    end
                end
            end
        endcase
    endfunction

    // mostly a small hot page set so that hits and drop hits are common
    function automatic pool_cmd_t random_pool_command();
        pool_cmd_t   c;
        int unsigned pick;
        pick   = $urandom_range(99);
        c.page = PAGE_W'($urandom);
        if (pick < 35)
        begin
            c.op   = OP_ACCESS;
            c.page = PAGE_W'($urandom_range(0, 47));
        end
        else if (pick < 50)
        begin
            c.op = OP_ACCESS;
        end
        else if (pick < 72)
        begin
            c.op = OP_CREATE;
        end
        else if (pick < 90)
        begin
            c.op = OP_DROP;
            if (pick < 86)
            begin
                c.page = PAGE_W'($urandom_range(0, 47));
            end
        end
        else
        begin
            c.op = OP_FLUSH;
        end
        return c;
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] op, logic [PAGE_W-1:0] page);
        pool_cmd_t c;
        c.op   = op;
        c.page = page;
        cmd_backlog.push_back(c);
    endfunction

    function automatic void check_field(string name, logic [PAGE_W-1:0] want,
                                        logic [PAGE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // command driver: valid holds until the transaction completes
    always @(posedge clk)
    begin
        bit        offer;
        pool_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            offer = cmd_valid;
            if (cmd_valid && cmd_if.ready)
            begin
                nxt.op   = cmd_op;
                nxt.page = cmd_page;
                apply_pool_command(nxt);
                offer = 1'b0;
            end
            if (!offer && cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt      = cmd_backlog.pop_front();
                cmd_op   <= nxt.op;
                cmd_page <= nxt.page;
                offer    = 1'b1;
            end
            cmd_valid <= offer;
        end
    end

    // result monitor with random back-pressure and a long hold-off on request
    always @(posedge clk)
    begin
        pool_result_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual page %h",
                             $time, res_if.page_number);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("hit", PAGE_W'(want.hit), PAGE_W'(res_if.hit));
                    check_field("slot", PAGE_W'(want.slot), PAGE_W'(res_if.slot));
                    check_field("page_number", want.page_number, res_if.page_number);
                    check_field("writeback_valid", PAGE_W'(want.wb_valid),
                                PAGE_W'(res_if.writeback_valid));
                    check_field("writeback_page", want.wb_page, res_if.writeback_page);
                    check_field("last", PAGE_W'(want.last), PAGE_W'(res_if.last));
                end
            end
            if (stall_seen != stall_requests)
            begin
                stall_seen = stall_requests;
                stall_left = 400;
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_valid || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // write slots_in_use, then read it back
    task automatic set_pool_size(logic [CFG_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SLOTS_IN_USE;
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        pool_size_reg = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== APB_DATA_W'(v))
        begin
            $display("%0t: slots_in_use readback mismatch, expected %h, actual %h",
                     $time, APB_DATA_W'(v), prdata);
            regread_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) cmd_backlog.push_back(random_pool_command());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n         <= 1'b1;
        send_idle_pct <= 27;
        recv_idle_pct <= 67;
        @(negedge clk);

        // directed: empty pool, extremes, duplicates from create numbering
        queue_cmd(OP_FLUSH, 16'h0000);
        queue_cmd(OP_DROP, 16'h1234);
        queue_cmd(OP_ACCESS, 16'h0000);
        queue_cmd(OP_ACCESS, 16'hFFFF);
        queue_cmd(OP_CREATE, 16'hFFFF);
        queue_cmd(OP_CREATE, 16'h5A5A);
        queue_cmd(OP_ACCESS, 16'h0002);
        queue_cmd(OP_CREATE, 16'h0000);
        queue_cmd(OP_ACCESS, 16'h0002);
        queue_cmd(OP_DROP, 16'h0002);
        queue_cmd(OP_ACCESS, 16'hFFFF);
        queue_cmd(OP_DROP, 16'h0000);
        queue_cmd(OP_ACCESS, 16'h8000);
        queue_cmd(OP_FLUSH, 16'hA5A5);
        queue_cmd(OP_FLUSH, 16'h0000);
        queue_random(60);

        // long result hold-off while commands keep coming
        stall_requests <= stall_requests + 1;
        queue_random(40);
        wait_drained();

        // no flush before shrinking: upper slots keep their pages
        set_pool_size(5'd3);
        queue_random(50);
        wait_drained();

        send_idle_pct <= 67;
        recv_idle_pct <= 27;
        set_pool_size(5'd0);
        queue_random(30);
        wait_drained();
        set_pool_size(5'd31);
        queue_random(60);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        set_pool_size(5'd1);
        queue_random(20);
        wait_drained();
        set_pool_size(5'd16);
        queue_random(50);
        wait_drained();

        // closing mix on a full-size pool
        @(negedge clk);
        queue_cmd(OP_ACCESS, 16'h0000);
        queue_cmd(OP_ACCESS, 16'hFFFF);
        queue_cmd(OP_DROP, 16'h0001);
        queue_cmd(OP_FLUSH, 16'h0000);
        queue_random(20);
        wait_drained();
        repeat (12) @(posedge clk);

        if (mismatch_count + regread_errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
